// ----- rtl/sndx_pkg.sv -----
// Package for the streaming Soundex coder.
// Holds letter constants, the letter code table, and the queue item types.
// No dependencies.
package sndx_pkg;

  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_DIGITS  = 3;
  localparam logic [1:0]  DIGITS_FULL = 2'(NUM_DIGITS);

  // Default queue depths (class queue between front and back, result queue).
  localparam int unsigned CLASS_DEPTH  = 2;
  localparam int unsigned RESULT_DEPTH = 2;

  // Soundex code per letter A..Z; H, W and Y count as vowels.
  localparam logic [2:0] CODE_TABLE [NUM_LETTERS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
    3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
  };

  // One classified byte, as handed from front to back.
  typedef struct packed {
    logic       is_letter;
    logic [7:0] upper;
    logic [2:0] code;
    logic       last;
  } class_item_t;

  // One finished code.
  typedef struct packed {
    logic [7:0] lead_letter;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
    logic       no_letters;
  } result_t;

endpackage

// ----- rtl/sndx_fifo.sv -----
// Small show-ahead queue built from flip-flops.
// Used between front and back and for finished results. No package needed.
module sndx_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/sndx_front.sv -----
// Front end of the Soundex coder: classifies each raw byte.
// Depends on sndx_pkg for letter constants, the code table and class_item_t.
module sndx_front (
  input  logic                 [7:0] char_in,
  input  logic                       last_char,
  output sndx_pkg::class_item_t      item
);
  import sndx_pkg::*;

  logic       is_upper;
  logic       is_lower;
  logic [7:0] upper;
  logic [4:0] letter_idx;

  assign is_upper   = (char_in >= UPPER_A) && (char_in <= UPPER_Z);
  assign is_lower   = (char_in >= LOWER_A) && (char_in <= LOWER_Z);
  assign upper      = is_lower ? (char_in - CASE_DIFF) : char_in;
  // Only meaningful for letters; clamp others to a valid table slot.
  assign letter_idx = (is_upper || is_lower) ? 5'(upper - UPPER_A) : 5'd0;

  always_comb begin
    item.is_letter = is_upper || is_lower;
    item.upper     = upper;
    item.code      = CODE_TABLE[letter_idx];
    item.last      = last_char;
  end

endmodule

// ----- rtl/sndx_back.sv -----
// Back end of the Soundex coder: run test, digit store and result forming.
// Depends on sndx_pkg for class_item_t, result_t and digit constants.
module sndx_back (
  input  logic                       clk,
  input  logic                       rst,
  input  sndx_pkg::class_item_t      item,
  input  logic                       item_valid,
  output logic                       item_take,
  input  logic                       res_full,
  output logic                       res_push,
  output sndx_pkg::result_t          res
);
  import sndx_pkg::*;

  logic       seen_letter, seen_letter_next;
  logic [7:0] first_letter, first_letter_next;
  logic [2:0] prev_code, prev_code_next;
  logic [1:0] digit_count, digit_count_next;
  logic [2:0] digit0, digit0_next;
  logic [2:0] digit1, digit1_next;
  logic [2:0] digit2, digit2_next;
  logic       add_digit;

  // A final byte needs room in the result queue; others always go.
  assign item_take = item_valid && (!item.last || !res_full);
  assign res_push  = item_take && item.last;

  always_comb begin
    seen_letter_next  = seen_letter;
    first_letter_next = first_letter;
    prev_code_next    = prev_code;
    digit_count_next  = digit_count;
    digit0_next       = digit0;
    digit1_next       = digit1;
    digit2_next       = digit2;
    add_digit         = 1'b0;

    if (item.is_letter) begin
      if (!seen_letter) begin
        seen_letter_next  = 1'b1;
        first_letter_next = item.upper;
      end else begin
        add_digit = (item.code != prev_code) && (item.code != 3'd0) &&
                    (digit_count < DIGITS_FULL);
      end
      prev_code_next = item.code;
    end

    if (add_digit) begin
      case (digit_count)
        2'd0:    digit0_next = item.code;
        2'd1:    digit1_next = item.code;
        default: digit2_next = item.code;
      endcase
      digit_count_next = digit_count + 1'b1;
    end

    res.lead_letter = seen_letter_next ? first_letter_next : 8'd0;
    res.digit_one   = digit0_next;
    res.digit_two   = digit1_next;
    res.digit_three = digit2_next;
    res.no_letters  = !seen_letter_next;
  end

  always_ff @(posedge clk) begin
    if (rst || res_push) begin
      seen_letter  <= 1'b0;
      first_letter <= '0;
      prev_code    <= '0;
      digit_count  <= '0;
      digit0       <= '0;
      digit1       <= '0;
      digit2       <= '0;
    end else if (item_take) begin
      seen_letter  <= seen_letter_next;
      first_letter <= first_letter_next;
      prev_code    <= prev_code_next;
      digit_count  <= digit_count_next;
      digit0       <= digit0_next;
      digit1       <= digit1_next;
      digit2       <= digit2_next;
    end
  end

endmodule

// ----- rtl/soundex_encoder_top.sv -----
// Streaming Soundex coder, top level. Uses sndx_pkg, sndx_front, sndx_fifo, sndx_back.
// Throughput: one byte per cycle, sustained, while results are drained.
// Path of a final byte: it waits in the class queue, then the back end forms the code
//   as it pushes it into the result queue, where it shows with empty low.
// Reset (rst, synchronous, active high) empties both queues and clears the
//   per-name state, so the next byte starts a new name.
module soundex_encoder_top #(
  parameter int unsigned CLASS_DEPTH  = sndx_pkg::CLASS_DEPTH,
  parameter int unsigned RESULT_DEPTH = sndx_pkg::RESULT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // input side: a transaction moves one byte of the name
  input  logic [7:0] char_in,
  input  logic       last_char,
  input  logic       push,
  output logic       full,
  // result side: a transaction moves one finished code
  output logic [7:0] lead_letter,
  output logic [2:0] digit_one,
  output logic [2:0] digit_two,
  output logic [2:0] digit_three,
  output logic       no_letters,
  output logic       empty,
  input  logic       pop
);
  import sndx_pkg::*;

  localparam int unsigned CLASS_W  = $bits(class_item_t);
  localparam int unsigned RESULT_W = $bits(result_t);

  class_item_t front_item;
  class_item_t back_item;
  logic        class_empty;
  logic        class_take;
  logic        res_full;
  logic        res_push;
  result_t     res_in;
  result_t     res_out;

  // Classify each byte: letter test, upper-casing, code lookup.
  sndx_front u_front (
    .char_in   (char_in),
    .last_char (last_char),
    .item      (front_item)
  );

  // Class queue: full here is full to the outside, so the front
  // stalls only when the back end has fallen behind.
  sndx_fifo #(
    .DEPTH (CLASS_DEPTH),
    .WIDTH (CLASS_W)
  ) u_class_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (class_take),
    .rdata (back_item),
    .empty (class_empty)
  );

  // Run test and digit store; on the final byte, push the finished code
  // and clear the per-name state in the same cycle.
  sndx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (!class_empty),
    .item_take  (class_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  // Result queue: hold finished codes until the consumer pops them, so a
  // waiting result holds back only a final byte, and only once this queue is full.
  sndx_fifo #(
    .DEPTH (RESULT_DEPTH),
    .WIDTH (RESULT_W)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign lead_letter = res_out.lead_letter;
  assign digit_one   = res_out.digit_one;
  assign digit_two   = res_out.digit_two;
  assign digit_three = res_out.digit_three;
  assign no_letters  = res_out.no_letters;

endmodule
